/* hdl/i2cbe_pkg.sv */
// Shared types and command codes for the I2C master bit engine.
package i2cbe_pkg;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STOP  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam int ITEM_BYTES   = 2;
    localparam int RESULT_BYTES = 2;

    typedef struct packed {
        logic       sda_sample;
        logic       send_nack;
        logic [7:0] write_byte;
        logic [1:0] op;
        logic       kind;
    } item_t;

    typedef struct packed {
        logic       rejected;
        logic       busy_res;
        logic       nack_seen;
        logic [7:0] read_byte;
        logic       done_res;
        logic       sda_release;
        logic       scl_level;
    } result_t;

endpackage

/* hdl/i2cbe_seq.sv */
// Phase sequencer: holds the bus state and computes the result of each item.
module i2cbe_seq
    import i2cbe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  item_t       item,
    input  logic [15:0] phase_ticks,
    output result_t     res
);

    localparam logic [4:0] PH_IDLE   = 5'd0;
    localparam logic [4:0] PH_ST_A   = 5'd1;
    localparam logic [4:0] PH_ST_B   = 5'd2;
    localparam logic [4:0] PH_SP_A   = 5'd3;
    localparam logic [4:0] PH_SP_B   = 5'd4;
    localparam logic [4:0] PH_WR_PRE = 5'd5;
    localparam logic [4:0] PH_WR_DAT = 5'd6;
    localparam logic [4:0] PH_WR_HI  = 5'd7;
    localparam logic [4:0] PH_WR_LO  = 5'd8;
    localparam logic [4:0] PH_WA_HI  = 5'd9;
    localparam logic [4:0] PH_WA_LO  = 5'd10;
    localparam logic [4:0] PH_NK_A   = 5'd11;
    localparam logic [4:0] PH_NK_B   = 5'd12;
    localparam logic [4:0] PH_RD_HI  = 5'd13;
    localparam logic [4:0] PH_RD_LO  = 5'd14;
    localparam logic [4:0] PH_RA_LO  = 5'd15;
    localparam logic [4:0] PH_RA_DAT = 5'd16;
    localparam logic [4:0] PH_RA_HI  = 5'd17;

    logic [4:0]  phase_reg, phase_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] tick_count_reg, tick_count_next;
    logic        ack_reg, ack_next;
    logic        nack_reg, nack_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic [7:0]  got_byte_reg, got_byte_next;

    logic [15:0] len;
    logic [16:0] tick_inc;
    logic        done;
    logic        rej;

    assign len      = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
    assign tick_inc = {1'b0, tick_count_reg} + 17'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        shift_next      = shift_reg;
        tick_count_next = tick_count_reg;
        ack_next        = ack_reg;
        nack_next       = nack_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        got_byte_next   = got_byte_reg;
        done            = 1'b0;
        rej             = 1'b0;
        if (item.kind)
        begin
            if (phase_reg != PH_IDLE)
            begin
                rej = 1'b1;
            end
            else
            begin
                tick_count_next = 16'd0;
                bit_count_next  = 4'd0;
                unique case (item.op)
                    OP_START:
                    begin
                        phase_next = PH_ST_A;
                        scl_next   = 1'b1;
                        sda_next   = 1'b1;
                    end
                    OP_STOP:
                    begin
                        phase_next = PH_SP_A;
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                    end
                    OP_WRITE:
                    begin
                        phase_next = PH_WR_PRE;
                        scl_next   = 1'b0;
                        shift_next = item.write_byte;
                        nack_next  = 1'b0;
                    end
                    default:
                    begin
                        phase_next = PH_RD_HI;
                        scl_next   = 1'b1;
                        sda_next   = 1'b1;
                        shift_next = 8'd0;
                        ack_next   = item.send_nack;
                    end
                endcase
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            if (tick_inc >= {1'b0, len})
            begin
                tick_count_next = 16'd0;
                unique case (phase_reg)
                    PH_ST_A:
                    begin
                        phase_next = PH_ST_B;
                        sda_next   = 1'b0;
                    end
                    PH_ST_B:
                    begin
                        scl_next   = 1'b0;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    PH_SP_A:
                    begin
                        phase_next = PH_SP_B;
                        scl_next   = 1'b1;
                    end
                    PH_SP_B, PH_NK_B:
                    begin
                        sda_next   = 1'b1;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    PH_WR_PRE, PH_WR_LO:
                    begin
                        if (bit_count_reg[3])
                        begin
                            phase_next = PH_WA_HI;
                            sda_next   = 1'b1;
                            scl_next   = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_WR_DAT;
                            sda_next   = shift_reg[7];
                            scl_next   = 1'b0;
                        end
                    end
                    PH_WR_DAT, PH_RA_DAT:
                    begin
                        phase_next = (phase_reg == PH_WR_DAT) ? PH_WR_HI : PH_RA_HI;
                        scl_next   = 1'b1;
                    end
                    PH_WR_HI:
                    begin
                        phase_next     = PH_WR_LO;
                        scl_next       = 1'b0;
                        shift_next     = {shift_reg[6:0], 1'b0};
                        bit_count_next = bit_count_reg + 4'd1;
                    end
                    PH_WA_HI:
                    begin
                        scl_next = 1'b0;
                        if (item.sda_sample)
                        begin
                            nack_next  = 1'b1;
                            phase_next = PH_NK_A;
                            sda_next   = 1'b0;
                        end
                        else
                        begin
                            phase_next = PH_WA_LO;
                        end
                    end
                    PH_WA_LO:
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    PH_NK_A:
                    begin
                        phase_next = PH_NK_B;
                        scl_next   = 1'b1;
                    end
                    PH_RD_HI:
                    begin
                        shift_next     = {shift_reg[6:0], item.sda_sample};
                        bit_count_next = bit_count_reg + 4'd1;
                        phase_next     = PH_RD_LO;
                        scl_next       = 1'b0;
                    end
                    PH_RD_LO:
                    begin
                        if (bit_count_reg[3])
                        begin
                            got_byte_next = shift_reg;
                            phase_next    = PH_RA_LO;
                        end
                        else
                        begin
                            phase_next = PH_RD_HI;
                            scl_next   = 1'b1;
                        end
                    end
                    PH_RA_LO:
                    begin
                        phase_next = PH_RA_DAT;
                        sda_next   = ack_reg;
                    end
                    PH_RA_HI:
                    begin
                        scl_next   = 1'b0;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            else
            begin
                tick_count_next = tick_inc[15:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_count_reg  <= 4'd0;
            shift_reg      <= 8'd0;
            tick_count_reg <= 16'd0;
            ack_reg        <= 1'b0;
            nack_reg       <= 1'b0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            got_byte_reg   <= 8'd0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            shift_reg      <= shift_next;
            tick_count_reg <= tick_count_next;
            ack_reg        <= ack_next;
            nack_reg       <= nack_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            got_byte_reg   <= got_byte_next;
        end
    end

    assign res.scl_level   = scl_next;
    assign res.sda_release = sda_next;
    assign res.done_res    = done;
    assign res.read_byte   = got_byte_next;
    assign res.nack_seen   = nack_next;
    assign res.busy_res    = (phase_next != PH_IDLE);
    assign res.rejected    = rej;

endmodule

/* hdl/i2c_master_bit_engine.sv */
// Top level of the I2C master bit engine: stream ports, APB register, result register.
//
// Usage:
//   Input stream (s_*): one transfer per item. s_tuser is the kind: 0 is a time
//   tick, 1 is a command. s_tdata carries the command and the sampled SDA level.
//   Output stream (m_*): exactly one result transfer per input transfer, in order,
//   with the SCL and SDA pin levels, completion, received byte and status flags.
//   APB port: register phase_ticks at byte address 0 (tick items per pin phase,
//   0 acts as 1); pready is always high, reads at address 0 return the register.
//   Output: a result appears on m_tvalid in the cycle after its input transfer.
//   Throughput: one item per cycle while m_tready keeps s_tready high; the sequencer
//   advances at most one phase per tick and its whole update sits between the input
//   transfer and the result register.
//   Stall: while a result waits on m_tready low, s_tready drops; the output
//   register holds and no state moves. s_tready returns as the result is taken.
//   Reset: both lines released, sequencer idle, phase_ticks 1, no result pending.
module i2c_master_bit_engine
    import i2cbe_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // [1:0] op, [9:2] write_byte, [10] send_nack, [11] sda_sample
    input  logic [8*ITEM_BYTES-1:0]   s_tdata,
    // [0] kind
    input  logic                      s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // [0] scl_level, [1] sda_release, [2] done_res, [10:3] read_byte,
    // [11] nack_seen, [12] busy_res, [13] rejected
    output logic [8*RESULT_BYTES-1:0] m_tdata,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    localparam int ItemBits   = $bits(item_t);
    localparam int ResultBits = $bits(result_t);

    logic        step;
    item_t       item;
    result_t     res;
    logic [15:0] phase_ticks_reg;
    logic        m_valid_reg;
    result_t     m_data_reg;
    logic        reg_sel;

    assign s_tready = !m_valid_reg || m_tready;
    assign step     = s_tvalid && s_tready;
    assign item     = {s_tdata[ItemBits-2:0], s_tuser};

    i2cbe_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .item        (item),
        .phase_ticks (phase_ticks_reg),
        .res         (res)
    );

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == 1'b0);
    assign prdata  = reg_sel ? {16'd0, phase_ticks_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= 16'd1;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            phase_ticks_reg <= pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            m_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            m_data_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(8*RESULT_BYTES-ResultBits){1'b0}}, m_data_reg};

endmodule

/* hdl/i2cbe_checker.sv */
// Port-level checker for the I2C master bit engine, bound to the top level.
module i2cbe_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[13] |-> m_tdata[12] && !m_tdata[2])
        else $error("rejected command without a running sequence");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |-> !m_tdata[12])
        else $error("sequence finished but still busy");

endmodule

bind i2c_master_bit_engine i2cbe_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
